// ===== rtl/core/mcbf_pkg.sv =====
package mcbf_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned CHF_W       = 4;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CNT_W       = 11;
  localparam int unsigned ST_W        = 3;
  localparam int unsigned CAP_W       = 11;
  localparam int unsigned CAP_RESET   = 1024;
  localparam int unsigned ALLOC_LIMIT = 16;

  localparam int unsigned NUM_CHANNELS_DEF = 16;
  localparam int unsigned MAX_DEPTH_DEF    = 1024;

  localparam logic [OP_W-1:0] OP_ALLOC    = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE    = 3'd1;
  localparam logic [OP_W-1:0] OP_READ     = 3'd2;
  localparam logic [OP_W-1:0] OP_SPLICE   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLOSE_RD = 3'd4;
  localparam logic [OP_W-1:0] OP_CLOSE_WR = 3'd5;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_INVALID = 3'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd3;
  localparam logic [ST_W-1:0] ST_BROKEN  = 3'd4;
  localparam logic [ST_W-1:0] ST_EOS     = 3'd5;
  localparam logic [ST_W-1:0] ST_NONE    = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHF_W-1:0]  channel;
    logic [CHF_W-1:0]  dest_channel;
    logic [BYTE_W-1:0] wdata;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [BYTE_W-1:0] rdata;
    logic [CHF_W-1:0]  new_channel;
    logic [CNT_W-1:0]  fill_count;
    logic              readable;
    logic              writable;
    logic              last_out;
  } out_item_t;

endpackage

// ===== rtl/core/multi_channel_byte_fifo.sv =====
// Byte FIFO channels sharing one byte store of 2**clog2(NUM_CHANNELS) x 2**clog2(MAX_DEPTH)
// entries; per-channel head, tail and fill live in a small channel table memory,
// end flags and the active flag in flip-flops, so no clearing pass follows reset.
// One item is processed at a time. Allocate, write, close and every failed
// operation go through accept, then table lookup and write-back; a successful
// read or splice adds a further step, the byte store read that follows the
// head pointer lookup. A result waiting on a stalled output holds the block
// until the output register frees. The capacity register may only be written
// while the block is idle.
module multi_channel_byte_fifo #(
  parameter int unsigned NUM_CHANNELS = mcbf_pkg::NUM_CHANNELS_DEF,
  parameter int unsigned MAX_DEPTH    = mcbf_pkg::MAX_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [mcbf_pkg::CAP_W-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  mcbf_pkg::in_item_t       in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output mcbf_pkg::out_item_t      out_item_o
);

  import mcbf_pkg::*;

  localparam int unsigned CH_W    = $clog2(NUM_CHANNELS);
  localparam int unsigned CH_N    = 1 << CH_W;
  localparam int unsigned PTR_W   = $clog2(MAX_DEPTH);
  localparam int unsigned FILL_W  = $clog2(MAX_DEPTH + 1);
  localparam int unsigned CMP_W   = FILL_W + 1;
  localparam int unsigned META_W  = 2 * PTR_W + FILL_W;
  localparam int unsigned SADDR_W = CH_W + PTR_W;
  localparam int unsigned ALLOC_N = (NUM_CHANNELS < ALLOC_LIMIT) ? NUM_CHANNELS : ALLOC_LIMIT;
  localparam int unsigned CAP_RST = (MAX_DEPTH < CAP_RESET) ? MAX_DEPTH : CAP_RESET;
  localparam logic [CH_N-1:0] ALLOC_MASK = CH_N'((64'd1 << ALLOC_N) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_FETCH = 4'b0100,
    S_HOLD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [FILL_W-1:0] cap_q;
  logic [CH_N-1:0]   active_q, active_d;
  logic [CH_N-1:0]   rd_open_q, rd_open_d;
  logic [CH_N-1:0]   wr_open_q, wr_open_d;

  logic [OP_W-1:0]   op_q;
  logic [CHF_W-1:0]  ch_q;
  logic [CHF_W-1:0]  dst_q;
  logic [BYTE_W-1:0] wdata_q;
  logic              last_q;

  logic [PTR_W-1:0]  dst_head_q, dst_head_d;
  logic [PTR_W-1:0]  dst_tail_q, dst_tail_d;
  logic [FILL_W-1:0] dst_fill_q, dst_fill_d;

  out_item_t res_q, fin, out_q;
  logic      out_valid_q;

  logic              accept;
  logic [META_W-1:0] ra_data, rb_data;
  logic              mw_en;
  logic [CH_W-1:0]   mw_addr;
  logic [META_W-1:0] mw_data;
  logic              sw_en, sr_en;
  logic [SADDR_W-1:0] sw_addr, sr_addr;
  logic [BYTE_W-1:0] sw_data, store_rd;

  logic [CH_W-1:0]   src_idx, dst_idx, grant_idx;
  logic              src_act, dst_act, grant_found;
  logic [PTR_W-1:0]  src_head, src_tail, d_head, d_tail;
  logic [FILL_W-1:0] src_fill, d_fill;
  logic [META_W-1:0] src_meta, dst_meta;

  logic [ST_W-1:0]   st;
  logic [CHF_W-1:0]  newch;
  logic [FILL_W-1:0] res_fill;
  logic              res_act;
  logic              need_fetch;
  logic              fin_valid;
  logic              slot_free;
  logic [CAP_W-1:0]  cfg_eff;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                input logic [FILL_W-1:0] cap);
    logic [PTR_W:0] n;
    n = {1'b0, p} + (PTR_W+1)'(1);
    return (CMP_W'(n) >= CMP_W'(cap)) ? '0 : n[PTR_W-1:0];
  endfunction

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  mcbf_ctab #(
    .CH_W   (CH_W),
    .DATA_W (META_W)
  ) u_ctab (
    .clk_i     (clk_i),
    .re_i      (accept),
    .ra_addr_i (CH_W'(in_item_i.channel)),
    .rb_addr_i (CH_W'(in_item_i.dest_channel)),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data),
    .we_i      (mw_en),
    .waddr_i   (mw_addr),
    .wdata_i   (mw_data)
  );

  mcbf_store #(
    .ADDR_W (SADDR_W)
  ) u_store (
    .clk_i   (clk_i),
    .re_i    (sr_en),
    .raddr_i (sr_addr),
    .rdata_o (store_rd),
    .we_i    (sw_en),
    .waddr_i (sw_addr),
    .wdata_i (sw_data)
  );

  assign src_idx = CH_W'(ch_q);
  assign dst_idx = CH_W'(dst_q);
  assign src_act = (32'(ch_q) < NUM_CHANNELS) && active_q[src_idx];
  assign dst_act = (32'(dst_q) < NUM_CHANNELS) && active_q[dst_idx];

  // inactive entries read as reset value
  assign src_meta = src_act ? ra_data : '0;
  assign dst_meta = dst_act ? rb_data : '0;
  assign src_head = src_meta[META_W-1 -: PTR_W];
  assign src_tail = src_meta[FILL_W +: PTR_W];
  assign src_fill = src_meta[FILL_W-1:0];
  assign d_head   = dst_meta[META_W-1 -: PTR_W];
  assign d_tail   = dst_meta[FILL_W +: PTR_W];
  assign d_fill   = dst_meta[FILL_W-1:0];

  always_comb begin
    grant_found = 1'b0;
    grant_idx   = '0;
    for (int i = ALLOC_N - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        grant_found = 1'b1;
        grant_idx   = CH_W'(i);
      end
    end
  end

  always_comb begin
    active_d   = active_q;
    rd_open_d  = rd_open_q;
    wr_open_d  = wr_open_q;
    mw_en      = 1'b0;
    mw_addr    = src_idx;
    mw_data    = '0;
    sw_en      = 1'b0;
    sw_addr    = {src_idx, src_tail};
    sw_data    = wdata_q;
    sr_en      = 1'b0;
    sr_addr    = {src_idx, src_head};
    st         = ST_OK;
    newch      = '0;
    res_fill   = src_fill;
    res_act    = src_act;
    need_fetch = 1'b0;
    dst_head_d = dst_head_q;
    dst_tail_d = dst_tail_q;
    dst_fill_d = dst_fill_q;

    if (state_q == S_LOOK) begin
      unique case (op_q) inside
        OP_ALLOC: begin
          res_fill = '0;
          res_act  = grant_found;
          if (grant_found) begin
            newch                = CHF_W'(grant_idx);
            active_d[grant_idx]  = 1'b1;
            rd_open_d[grant_idx] = 1'b1;
            wr_open_d[grant_idx] = 1'b1;
            mw_en                = 1'b1;
            mw_addr              = grant_idx;
            mw_data              = '0;
          end else begin
            st = ST_NONE;
          end
        end
        OP_WRITE: begin
          if (!src_act) begin
            st = ST_INVALID;
          end else if (!rd_open_q[src_idx]) begin
            st = ST_BROKEN;
          end else if (CMP_W'(src_fill) >= CMP_W'(cap_q)) begin
            st = ST_FULL;
          end else begin
            sw_en    = 1'b1;
            res_fill = src_fill + FILL_W'(1);
            mw_en    = 1'b1;
            mw_data  = {src_head, next_ptr(src_tail, cap_q), res_fill};
          end
        end
        OP_READ: begin
          if (!src_act) begin
            st = ST_INVALID;
          end else if (src_fill == '0) begin
            st = wr_open_q[src_idx] ? ST_EMPTY : ST_EOS;
          end else begin
            sr_en      = 1'b1;
            need_fetch = 1'b1;
            res_fill   = src_fill - FILL_W'(1);
            mw_en      = 1'b1;
            mw_data    = {next_ptr(src_head, cap_q), src_tail, res_fill};
          end
        end
        OP_SPLICE: begin
          if (!src_act || !dst_act) begin
            st      = ST_INVALID;
            res_act = 1'b0;
          end else if (src_fill == '0) begin
            st = wr_open_q[src_idx] ? ST_EMPTY : ST_EOS;
          end else if (CMP_W'(d_fill) >= CMP_W'(cap_q)) begin
            st = rd_open_q[dst_idx] ? ST_FULL : ST_BROKEN;
          end else begin
            sr_en      = 1'b1;
            need_fetch = 1'b1;
            mw_en      = 1'b1;
            mw_data    = {next_ptr(src_head, cap_q), src_tail, src_fill - FILL_W'(1)};
            if (src_idx == dst_idx) begin
              // push lands on the entry just popped
              dst_head_d = next_ptr(src_head, cap_q);
              dst_tail_d = src_tail;
              dst_fill_d = src_fill - FILL_W'(1);
              res_fill   = src_fill;
            end else begin
              dst_head_d = d_head;
              dst_tail_d = d_tail;
              dst_fill_d = d_fill;
              res_fill   = src_fill - FILL_W'(1);
            end
          end
        end
        OP_CLOSE_RD, OP_CLOSE_WR: begin
          if (!src_act) begin
            st = ST_INVALID;
          end else begin
            if (op_q == OP_CLOSE_RD) begin
              rd_open_d[src_idx] = 1'b0;
            end else begin
              wr_open_d[src_idx] = 1'b0;
            end
            if (!rd_open_d[src_idx] && !wr_open_d[src_idx]) begin
              active_d[src_idx] = 1'b0;
              res_act           = 1'b0;
            end
          end
        end
        default: begin
          st      = ST_INVALID;
          res_act = 1'b0;
        end
      endcase
    end

    if (state_q == S_FETCH && op_q == OP_SPLICE) begin
      sw_en   = 1'b1;
      sw_addr = {dst_idx, dst_tail_q};
      sw_data = store_rd;
      mw_en   = 1'b1;
      mw_addr = dst_idx;
      mw_data = {dst_head_q, next_ptr(dst_tail_q, cap_q), dst_fill_q + FILL_W'(1)};
    end
  end

  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    fin       = res_q;
    fin_valid = 1'b0;
    state_d   = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        fin.status      = st;
        fin.rdata       = '0;
        fin.new_channel = newch;
        fin.fill_count  = res_act ? CNT_W'(res_fill) : '0;
        fin.readable    = res_act && (res_fill != '0);
        fin.writable    = res_act && (CMP_W'(res_fill) < CMP_W'(cap_q));
        fin.last_out    = last_q;
        fin_valid       = !need_fetch;
        if (need_fetch) begin
          state_d = S_FETCH;
        end else begin
          state_d = slot_free ? S_IDLE : S_HOLD;
        end
      end
      S_FETCH: begin
        fin.rdata = store_rd;
        fin_valid = 1'b1;
        state_d   = slot_free ? S_IDLE : S_HOLD;
      end
      S_HOLD: begin
        fin_valid = 1'b1;
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_eff = CAP_W'(1);
    end else if (32'(cfg_wdata_i) > MAX_DEPTH) begin
      cfg_eff = CAP_W'(MAX_DEPTH);
    end else begin
      cfg_eff = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= FILL_W'(CAP_RST);
      active_q    <= '0;
      rd_open_q   <= '0;
      wr_open_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      rd_open_q <= rd_open_d;
      wr_open_q <= wr_open_d;
      if (cfg_we_i) begin
        cap_q <= FILL_W'(cfg_eff);
      end
      if (fin_valid && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= in_item_i.op;
      ch_q    <= in_item_i.channel;
      dst_q   <= in_item_i.dest_channel;
      wdata_q <= in_item_i.wdata;
      last_q  <= in_item_i.last_in;
    end
    if (state_q == S_LOOK) begin
      dst_head_q <= dst_head_d;
      dst_tail_q <= dst_tail_d;
      dst_fill_q <= dst_fill_d;
    end
    if (state_q == S_LOOK || state_q == S_FETCH) begin
      res_q <= fin;
    end
    if (fin_valid && slot_free) begin
      out_q <= fin;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_accept_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_LOOK))
    else $error("accepted item did not move to table lookup");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register lost one-hot encoding");

  a_alloc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q & ~ALLOC_MASK) == '0)
    else $error("channel beyond allocation range is active");

  a_ends_of_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((rd_open_q | wr_open_q) & ~active_q) == '0)
    else $error("open end on a free channel");

  a_err_no_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == ST_INVALID || out_item_o.status == ST_NONE))
      |-> (out_item_o.fill_count == '0 && !out_item_o.readable && !out_item_o.writable))
    else $error("error result carries channel fill");
`endif

endmodule

// ===== rtl/core/mcbf_ctab.sv =====
module mcbf_ctab #(
  parameter int unsigned CH_W   = 4,
  parameter int unsigned DATA_W = 31
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [CH_W-1:0]   ra_addr_i,
  input  logic [CH_W-1:0]   rb_addr_i,
  output logic [DATA_W-1:0] ra_data_o,
  output logic [DATA_W-1:0] rb_data_o,
  input  logic              we_i,
  input  logic [CH_W-1:0]   waddr_i,
  input  logic [DATA_W-1:0] wdata_i
);

  localparam int unsigned DEPTH = 1 << CH_W;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] ra_q;
  logic [DATA_W-1:0] rb_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      ra_q <= mem_q[ra_addr_i];
      rb_q <= mem_q[rb_addr_i];
    end
  end

  assign ra_data_o = ra_q;
  assign rb_data_o = rb_q;

endmodule

// ===== rtl/core/mcbf_store.sv =====
module mcbf_store #(
  parameter int unsigned ADDR_W = 14
) (
  input  logic              clk_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [7:0]        rdata_o,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [7:0]        wdata_i
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rd_q;

endmodule
